// File: sv/plob_pkg.sv
// ----------------------------------------------------------------------------
// Price level order book package
// Sizes, field codes and derived widths used by the order book module.
// ----------------------------------------------------------------------------
`default_nettype none
package plob_pkg;
   localparam int LEVELS   = 1024;
   localparam int ORDERS   = 4096;
   localparam int LVL_AW   = $clog2(LEVELS);
   localparam int LMEM_AW  = LVL_AW + 1;
   localparam int ORD_AW   = $clog2(ORDERS);
   localparam int CNT_W    = ORD_AW + 1;
   localparam int LVL_W    = 33;
   localparam int ENT_W    = 64;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_MODIFY = 2'd1;
   localparam logic [1:0] ACT_DELETE = 2'd2;
   localparam logic [1:0] ACT_NONE   = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ID_ERR   = 2'd1;
   localparam logic [1:0] ST_WINDOW   = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic SIDE_BID = 1'b0;
   localparam logic SIDE_ASK = 1'b1;
endpackage
`default_nettype wire

// File: sv/plob_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module plob_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// File: sv/price_level_order_book.sv
// ----------------------------------------------------------------------------
// Price level order book
// Order table lookup, level quantity update and best price tracking.
// ----------------------------------------------------------------------------
// Each item first scans the order table for its id. A rejected item then gives
// its result; an insert or a modify updates its level, and a delete also moves
// the last entry into the freed slot and, when the best level empties, searches
// the levels on that side for the next best. An ACT_NONE item skips the scan.
// One item at a time: busy falls with the result strobe; the receiver cannot stall.
// After reset a clearing pass zeroes the level memory.
`default_nettype none
module price_level_order_book (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic        req_side,
   input  wire logic [31:0] req_order_id,
   input  wire logic [31:0] req_price_tick,
   input  wire logic [31:0] req_quantity,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_top_bid_price,
   output logic             rsp_top_bid_valid,
   output logic [31:0]      rsp_top_ask_price,
   output logic             rsp_top_ask_valid,
   output logic [32:0]      rsp_mid_times_two,
   output logic             rsp_crossed
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_CHECK, S_SCAN_RD, S_SCAN_CK, S_DECIDE, S_MOVE_RD,
      S_MOVE_WR, S_LVL_RD, S_LVL_WR, S_SRCH_RD, S_SRCH_CK, S_DONE
   } state_type;

   state_type state_ff;

   logic [1:0]  action_ff;
   logic        side_ff;
   logic [31:0] id_ff;
   logic [31:0] price_ff;
   logic [31:0] qty_ff;

   logic [32:0] anchor_ff    [2];
   logic        anchor_ok_ff [2];
   logic [plob_pkg::LVL_AW-1:0] top_ff [2];
   logic        top_ok_ff    [2];

   logic [plob_pkg::CNT_W-1:0]   count_ff;
   logic [plob_pkg::ORD_AW-1:0]  scan_ff;
   logic [plob_pkg::ORD_AW-1:0]  ent_ff;
   logic [31:0]                  ent_qty_ff;
   logic                         found_ff;
   logic                         win_ff;
   logic [plob_pkg::LVL_AW-1:0]  idx_ff;
   logic [31:0]                  delta_ff;
   logic [plob_pkg::LVL_AW-1:0]  srch_ff;
   logic [plob_pkg::LMEM_AW-1:0] clr_ff;
   logic [1:0]                   status_ff;

   logic                         ent_we;
   logic [plob_pkg::ORD_AW-1:0]  ent_waddr;
   logic [plob_pkg::ENT_W-1:0]   ent_wdata;
   logic [plob_pkg::ORD_AW-1:0]  ent_raddr;
   logic [plob_pkg::ENT_W-1:0]   ent_rdata;

   logic                         lvl_we;
   logic [plob_pkg::LMEM_AW-1:0] lvl_waddr;
   logic [plob_pkg::LVL_W-1:0]   lvl_wdata;
   logic [plob_pkg::LMEM_AW-1:0] lvl_raddr;
   logic [plob_pkg::LVL_W-1:0]   lvl_rdata;

   logic [33:0] diff;
   logic [31:0] new_qty;
   logic        new_occ;
   logic [32:0] bid_sum;
   logic [32:0] ask_sum;
   logic [31:0] bp;
   logic [31:0] ap;

   assign busy = (state_ff != S_IDLE);

   // Level index relative to the side's anchor, in 34 bits so that both
   // directions of leaving the window are seen.
   assign diff = {2'b00, price_ff} - {anchor_ff[side_ff][32], anchor_ff[side_ff]};

   always_comb begin
      new_qty = lvl_rdata[31:0] + delta_ff;
      unique case (action_ff)
         plob_pkg::ACT_INSERT: new_occ = 1'b1;
         plob_pkg::ACT_DELETE: new_occ = (new_qty != 32'd0) ? lvl_rdata[32] : 1'b0;
         default:              new_occ = lvl_rdata[32];
      endcase
   end

   assign bid_sum = anchor_ff[0] + {{(33 - plob_pkg::LVL_AW){1'b0}}, top_ff[0]};
   assign ask_sum = anchor_ff[1] + {{(33 - plob_pkg::LVL_AW){1'b0}}, top_ff[1]};
   assign bp = top_ok_ff[0] ? bid_sum[31:0] : 32'd0;
   assign ap = top_ok_ff[1] ? ask_sum[31:0] : 32'd0;

   always_comb begin
      ent_we    = 1'b0;
      ent_waddr = ent_ff;
      ent_wdata = {id_ff, qty_ff};
      ent_raddr = scan_ff;
      if (state_ff == S_DECIDE && found_ff == 1'b0 && action_ff == plob_pkg::ACT_INSERT
          && count_ff != plob_pkg::CNT_W'(plob_pkg::ORDERS)) begin
         ent_we    = 1'b1;
         ent_waddr = count_ff[plob_pkg::ORD_AW-1:0];
      end else if (state_ff == S_DECIDE && found_ff && win_ff
                   && action_ff == plob_pkg::ACT_MODIFY) begin
         ent_we = 1'b1;
      end else if (state_ff == S_MOVE_WR) begin
         ent_we    = 1'b1;
         ent_wdata = ent_rdata;
      end
      if (state_ff == S_MOVE_RD) begin
         ent_raddr = count_ff[plob_pkg::ORD_AW-1:0];
      end
   end

   always_comb begin
      lvl_we    = 1'b0;
      lvl_waddr = {side_ff, idx_ff};
      lvl_wdata = {new_occ, new_qty};
      lvl_raddr = {side_ff, idx_ff};
      if (state_ff == S_CLEAR) begin
         lvl_we    = 1'b1;
         lvl_waddr = clr_ff;
         lvl_wdata = '0;
      end else if (state_ff == S_LVL_WR) begin
         lvl_we = 1'b1;
      end
      if (state_ff == S_SRCH_RD) begin
         lvl_raddr = {side_ff, srch_ff};
      end
   end

   plob_ram #(.WIDTH(plob_pkg::ENT_W), .DEPTH(plob_pkg::ORDERS)) u_entries (
      .clock(clock), .wr_en(ent_we), .wr_addr(ent_waddr), .wr_data(ent_wdata),
      .rd_addr(ent_raddr), .rd_data(ent_rdata)
   );

   plob_ram #(.WIDTH(plob_pkg::LVL_W), .DEPTH(2 * plob_pkg::LEVELS)) u_levels (
      .clock(clock), .wr_en(lvl_we), .wr_addr(lvl_waddr), .wr_data(lvl_wdata),
      .rd_addr(lvl_raddr), .rd_data(lvl_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         clr_ff          <= '0;
         count_ff        <= '0;
         anchor_ok_ff[0] <= 1'b0;
         anchor_ok_ff[1] <= 1'b0;
         top_ok_ff[0]    <= 1'b0;
         top_ok_ff[1]    <= 1'b0;
         rsp_valid       <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == {plob_pkg::LMEM_AW{1'b1}}) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  action_ff <= req_action;
                  side_ff   <= req_side;
                  id_ff     <= req_order_id;
                  price_ff  <= req_price_tick;
                  qty_ff    <= req_quantity;
                  state_ff  <= S_CHECK;
               end
            end
            S_CHECK: begin
               status_ff <= plob_pkg::ST_OK;
               found_ff  <= 1'b0;
               scan_ff   <= '0;
               if (action_ff == plob_pkg::ACT_INSERT && !anchor_ok_ff[side_ff]) begin
                  // First order on this side centres the window on its price.
                  anchor_ff[side_ff]    <= {1'b0, price_ff} - 33'(plob_pkg::LEVELS / 2);
                  anchor_ok_ff[side_ff] <= 1'b1;
                  win_ff <= 1'b1;
                  idx_ff <= plob_pkg::LVL_AW'(plob_pkg::LEVELS / 2);
               end else begin
                  win_ff <= anchor_ok_ff[side_ff] && !diff[33]
                            && (diff[32:0] <= 33'(plob_pkg::LEVELS - 1));
                  idx_ff <= diff[plob_pkg::LVL_AW-1:0];
               end
               if (action_ff == plob_pkg::ACT_NONE) begin
                  state_ff <= S_DONE;
               end else if (count_ff == '0) begin
                  state_ff <= S_DECIDE;
               end else begin
                  state_ff <= S_SCAN_RD;
               end
            end
            S_SCAN_RD: begin
               state_ff <= S_SCAN_CK;
            end
            S_SCAN_CK: begin
               if (ent_rdata[63:32] == id_ff) begin
                  found_ff   <= 1'b1;
                  ent_ff     <= scan_ff;
                  ent_qty_ff <= ent_rdata[31:0];
                  state_ff   <= S_DECIDE;
               end else if (({1'b0, scan_ff} + plob_pkg::CNT_W'(1)) == count_ff) begin
                  state_ff <= S_DECIDE;
               end else begin
                  scan_ff  <= scan_ff + 1'b1;
                  state_ff <= S_SCAN_RD;
               end
            end
            S_DECIDE: begin
               priority if (action_ff == plob_pkg::ACT_INSERT) begin
                  priority if (!win_ff) begin
                     status_ff <= plob_pkg::ST_WINDOW;
                     state_ff  <= S_DONE;
                  end else if (found_ff) begin
                     status_ff <= plob_pkg::ST_ID_ERR;
                     state_ff  <= S_DONE;
                  end else if (count_ff == plob_pkg::CNT_W'(plob_pkg::ORDERS)) begin
                     status_ff <= plob_pkg::ST_FULL;
                     state_ff  <= S_DONE;
                  end else begin
                     count_ff <= count_ff + 1'b1;
                     delta_ff <= qty_ff;
                     state_ff <= S_LVL_RD;
                  end
               end else begin
                  priority if (!found_ff) begin
                     status_ff <= plob_pkg::ST_ID_ERR;
                     state_ff  <= S_DONE;
                  end else if (!win_ff) begin
                     status_ff <= plob_pkg::ST_WINDOW;
                     state_ff  <= S_DONE;
                  end else if (action_ff == plob_pkg::ACT_MODIFY) begin
                     delta_ff <= qty_ff - ent_qty_ff;
                     state_ff <= S_LVL_RD;
                  end else begin
                     // The last entry moves into the freed slot to keep the
                     // table packed below the fill count.
                     delta_ff <= 32'd0 - qty_ff;
                     count_ff <= count_ff - 1'b1;
                     state_ff <= S_MOVE_RD;
                  end
               end
            end
            S_MOVE_RD: begin
               state_ff <= S_MOVE_WR;
            end
            S_MOVE_WR: begin
               state_ff <= S_LVL_RD;
            end
            S_LVL_RD: begin
               state_ff <= S_LVL_WR;
            end
            S_LVL_WR: begin
               state_ff <= S_DONE;
               if (action_ff == plob_pkg::ACT_INSERT) begin
                  if (!top_ok_ff[side_ff]
                      || (side_ff == plob_pkg::SIDE_ASK && idx_ff < top_ff[side_ff])
                      || (side_ff == plob_pkg::SIDE_BID && idx_ff > top_ff[side_ff])) begin
                     top_ff[side_ff]    <= idx_ff;
                     top_ok_ff[side_ff] <= 1'b1;
                  end
               end else if (action_ff == plob_pkg::ACT_DELETE && new_qty == 32'd0
                            && top_ok_ff[side_ff] && top_ff[side_ff] == idx_ff) begin
                  top_ok_ff[side_ff] <= 1'b0;
                  top_ff[side_ff]    <= '0;
                  if (side_ff == plob_pkg::SIDE_ASK
                      && idx_ff != plob_pkg::LVL_AW'(plob_pkg::LEVELS - 1)) begin
                     srch_ff  <= idx_ff + 1'b1;
                     state_ff <= S_SRCH_RD;
                  end else if (side_ff == plob_pkg::SIDE_BID && idx_ff != '0) begin
                     srch_ff  <= idx_ff - 1'b1;
                     state_ff <= S_SRCH_RD;
                  end
               end
            end
            S_SRCH_RD: begin
               state_ff <= S_SRCH_CK;
            end
            S_SRCH_CK: begin
               if (lvl_rdata[32]) begin
                  top_ff[side_ff]    <= srch_ff;
                  top_ok_ff[side_ff] <= 1'b1;
                  state_ff           <= S_DONE;
               end else if (side_ff == plob_pkg::SIDE_ASK) begin
                  if (srch_ff == plob_pkg::LVL_AW'(plob_pkg::LEVELS - 1)) begin
                     state_ff <= S_DONE;
                  end else begin
                     srch_ff  <= srch_ff + 1'b1;
                     state_ff <= S_SRCH_RD;
                  end
               end else begin
                  if (srch_ff == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     srch_ff  <= srch_ff - 1'b1;
                     state_ff <= S_SRCH_RD;
                  end
               end
            end
            S_DONE: begin
               rsp_valid         <= 1'b1;
               rsp_status        <= status_ff;
               rsp_top_bid_price <= bp;
               rsp_top_bid_valid <= top_ok_ff[0];
               rsp_top_ask_price <= ap;
               rsp_top_ask_valid <= top_ok_ff[1];
               rsp_mid_times_two <= (top_ok_ff[0] && top_ok_ff[1])
                                    ? ({1'b0, bp} + {1'b0, ap}) : 33'd0;
               rsp_crossed       <= top_ok_ff[0] && top_ok_ff[1] && (bp >= ap);
               state_ff          <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// File: sv/plob_checker.sv
// ----------------------------------------------------------------------------
// Price level order book checker
// Port level checks of the command handshake and the result fields.
// ----------------------------------------------------------------------------
`default_nettype none
module plob_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_top_bid_valid,
   input wire logic        rsp_top_ask_valid,
   input wire logic [32:0] rsp_mid_times_two,
   input wire logic        rsp_crossed
);
   // An accepted item raises busy.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("accepted item did not raise busy");

   a_strobe_once: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result shown while still busy");

   a_one_sided: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !(rsp_top_bid_valid && rsp_top_ask_valid))
      |-> (rsp_mid_times_two == 33'd0 && !rsp_crossed))
      else $error("mid or crossed set with one side empty");
endmodule

bind price_level_order_book plob_checker u_plob_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .rsp_valid(rsp_valid), .rsp_top_bid_valid(rsp_top_bid_valid),
   .rsp_top_ask_valid(rsp_top_ask_valid), .rsp_mid_times_two(rsp_mid_times_two),
   .rsp_crossed(rsp_crossed)
);
`default_nettype wire
